// ===== hdl/pwmp_pkg.sv =====
package pwmp_pkg;

    typedef enum logic [2:0] {
        PH_HS,
        PH_LEN,
        PH_ID,
        PH_BODY,
        PH_ERR
    } phase_t;

    typedef enum logic [3:0] {
        EV_HS_OK        = 4'd0,
        EV_KEEPALIVE    = 4'd1,
        EV_CHOKE        = 4'd2,
        EV_UNCHOKE      = 4'd3,
        EV_INTERESTED   = 4'd4,
        EV_UNINTERESTED = 4'd5,
        EV_HAVE         = 4'd6,
        EV_BITFIELD     = 4'd7,
        EV_REQUEST      = 4'd8,
        EV_PIECE_START  = 4'd9,
        EV_PIECE_BYTE   = 4'd10,
        EV_CANCEL       = 4'd11,
        EV_SKIPPED      = 4'd12,
        EV_ERROR        = 4'd13
    } event_t;

    typedef enum logic [2:0] {
        FC_NONE     = 3'd0,
        FC_PROTOCOL = 3'd1,
        FC_HASH     = 3'd2,
        FC_SELF     = 3'd3,
        FC_LARGE    = 3'd4,
        FC_LENGTH   = 3'd5,
        FC_SPARE    = 3'd6
    } fault_t;

    typedef enum logic [1:0] {
        MM_NONE  = 2'd0,
        MM_PROTO = 2'd1,
        MM_HASH  = 2'd2
    } mismatch_t;

    localparam logic [2:0] REG_IH_HI  = 3'd0;
    localparam logic [2:0] REG_IH_MID = 3'd1;
    localparam logic [2:0] REG_IH_LO  = 3'd2;
    localparam logic [2:0] REG_ID_HI  = 3'd3;
    localparam logic [2:0] REG_ID_MID = 3'd4;
    localparam logic [2:0] REG_ID_LO  = 3'd5;
    localparam logic [2:0] REG_BLOCK  = 3'd6;
    localparam logic [2:0] REG_PIECES = 3'd7;

    localparam logic [7:0] ID_HAVE     = 8'd4;
    localparam logic [7:0] ID_BITFIELD = 8'd5;
    localparam logic [7:0] ID_REQUEST  = 8'd6;
    localparam logic [7:0] ID_PIECE    = 8'd7;
    localparam logic [7:0] ID_CANCEL   = 8'd8;

    localparam int HS_LEN = 68;

    localparam logic [159:0] HS_STR =
        {8'd19, "BitTorrent protocol"};

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } qword_t;

    typedef struct packed {
        event_t      kind;
        logic [31:0] piece_number;
        logic [31:0] byte_offset;
        logic [31:0] span_length;
        logic [7:0]  payload_byte;
        logic        last_byte;
        fault_t      fault_code;
    } result_t;

endpackage

// ===== hdl/pwmp_front.sv =====
module pwmp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_ready,
    input  logic [7:0]         rx_byte,
    output pwmp_pkg::qword_t   head,
    input  logic               pop
);
    import pwmp_pkg::*;

    logic [7:0] slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       take;

    assign rx_ready   = (count_reg != 2'd2);
    assign push       = rx_valid && rx_ready;
    assign head.valid = (count_reg != 2'd0);
    assign head.data  = slot_reg[rd_ptr_reg];
    assign take       = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= rx_byte;
        end
    end

endmodule

// ===== hdl/pwmp_back.sv =====
module pwmp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data,
    input  pwmp_pkg::qword_t   head,
    output logic               pop,
    output logic               ev_valid,
    input  logic               ev_ready,
    output pwmp_pkg::result_t  res
);
    import pwmp_pkg::*;

    logic [63:0] ih_hi_reg, ih_mid_reg, id_hi_reg, id_mid_reg;
    logic [31:0] ih_lo_reg, id_lo_reg;
    logic [20:0] block_reg, pieces_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] len_reg, len_next;
    logic [7:0]  kind_reg, kind_next;
    logic [31:0] fw_reg [3];
    logic [31:0] fw_next [3];
    mismatch_t   mm_reg, mm_next;
    logic        diff_reg, diff_next;

    logic        out_valid_reg, out_valid_next;
    result_t     res_reg, res_next;

    logic        has_res;
    logic        go_fault, go_end, go_id, go_body;

    logic [7:0]  b;
    logic [159:0] hash_key, id_key;
    logic [4:0]  hk, ik;
    logic [7:0]  hash_byte, id_byte, hs_byte;
    logic [31:0] len_full;
    logic        last;
    logic [1:0]  w;
    logic [18:0] bf_size;

    assign b        = head.data;
    assign pop      = head.valid && (!out_valid_reg || ev_ready);
    assign ev_valid = out_valid_reg;
    assign res      = res_reg;

    assign hash_key  = {ih_hi_reg, ih_mid_reg, ih_lo_reg};
    assign id_key    = {id_hi_reg, id_mid_reg, id_lo_reg};
    assign hk        = 5'(pos_reg - 32'd28);
    assign ik        = 5'(pos_reg - 32'd48);
    assign hash_byte = hash_key[8 * (5'd19 - hk) +: 8];
    assign id_byte   = id_key[8 * (5'd19 - ik) +: 8];
    assign hs_byte   = HS_STR[8 * (5'd19 - pos_reg[4:0]) +: 8];
    assign len_full  = {len_reg[23:0], b};
    assign last      = (pos_reg + 32'd1) == (len_reg - 32'd1);
    assign w         = pos_reg[3:2];
    assign bf_size   = 19'((22'(pieces_reg) + 22'd7) >> 3);

    always_comb
    begin
        res_next    = '0;
        has_res     = 1'b0;
        go_fault    = 1'b0;
        go_end      = 1'b0;
        go_id       = 1'b0;
        go_body     = 1'b0;
        pos_next    = pos_reg;
        len_next    = len_reg;
        kind_next   = kind_reg;
        fw_next     = fw_reg;
        mm_next     = mm_reg;
        diff_next   = diff_reg;
        unique case (phase_reg)
            PH_HS:
            begin
                if (pos_reg < 32'd4)
                begin
                    if (b != hs_byte)
                    begin
                        mm_next = MM_PROTO;
                    end
                end
                else if (pos_reg < 32'd20)
                begin
                    if (b != hs_byte && mm_reg == MM_NONE)
                    begin
                        mm_next = MM_PROTO;
                    end
                end
                else if (pos_reg >= 32'd28 && pos_reg < 32'd48)
                begin
                    if (b != hash_byte && mm_reg == MM_NONE)
                    begin
                        mm_next = MM_HASH;
                    end
                end
                else if (pos_reg >= 32'd48 && pos_reg < 32'(HS_LEN))
                begin
                    if (b != id_byte)
                    begin
                        diff_next = 1'b1;
                    end
                end
                pos_next = pos_reg + 32'd1;
                if (pos_reg == 32'd3 && mm_next != MM_NONE)
                begin
                    go_fault           = 1'b1;
                    res_next.fault_code = FC_PROTOCOL;
                end
                else if (pos_reg >= 32'(HS_LEN - 1))
                begin
                    if (mm_next == MM_PROTO)
                    begin
                        go_fault            = 1'b1;
                        res_next.fault_code = FC_PROTOCOL;
                    end
                    else if (mm_next != MM_NONE)
                    begin
                        go_fault            = 1'b1;
                        res_next.fault_code = FC_HASH;
                    end
                    else if (!diff_next)
                    begin
                        go_fault            = 1'b1;
                        res_next.fault_code = FC_SELF;
                    end
                    else
                    begin
                        diff_next     = 1'b0;
                        go_end        = 1'b1;
                        pos_next      = '0;
                        has_res       = 1'b1;
                        res_next.kind = EV_HS_OK;
                    end
                end
            end
            PH_LEN:
            begin
                len_next = (pos_reg == 32'd0) ? {24'd0, b} : len_full;
                pos_next = pos_reg + 32'd1;
                if (pos_reg == 32'd3)
                begin
                    pos_next = '0;
                    if ({1'b0, len_full} > (33'(block_reg) + 33'd9))
                    begin
                        go_fault            = 1'b1;
                        res_next.fault_code = FC_LARGE;
                    end
                    else if (len_full == 32'd0)
                    begin
                        has_res       = 1'b1;
                        res_next.kind = EV_KEEPALIVE;
                    end
                    else
                    begin
                        go_id = 1'b1;
                    end
                end
            end
            PH_ID:
            begin
                kind_next = b;
                pos_next  = '0;
                fw_next   = '{default: 32'd0};
                go_body   = 1'b1;
                if (b <= 8'd3)
                begin
                    if (len_reg != 32'd1)
                    begin
                        go_fault = 1'b1;
                    end
                    else
                    begin
                        go_end        = 1'b1;
                        has_res       = 1'b1;
                        res_next.kind = event_t'(4'd2 + b[3:0]);
                    end
                end
                else if (b == ID_HAVE)
                begin
                    go_fault = (len_reg != 32'd5);
                end
                else if (b == ID_BITFIELD)
                begin
                    go_fault = (len_reg != (32'(bf_size) + 32'd1));
                    go_end   = (len_reg == 32'd1);
                end
                else if (b == ID_REQUEST || b == ID_CANCEL)
                begin
                    go_fault = (len_reg != 32'd13);
                end
                else if (b == ID_PIECE)
                begin
                    go_fault = (len_reg < 32'd9);
                end
                else
                begin
                    go_end        = (len_reg == 32'd1);
                    has_res       = 1'b1;
                    res_next.kind = EV_SKIPPED;
                end
                if (go_fault)
                begin
                    res_next.fault_code = FC_LENGTH;
                end
            end
            PH_BODY:
            begin
                pos_next = pos_reg + 32'd1;
                go_end   = last;
                if (kind_reg == ID_BITFIELD)
                begin
                    if (last && pieces_reg[2:0] != 3'd0 && 8'(b << pieces_reg[2:0]) != 8'd0)
                    begin
                        go_fault            = 1'b1;
                        res_next.fault_code = FC_SPARE;
                    end
                    else
                    begin
                        has_res               = 1'b1;
                        res_next.kind         = EV_BITFIELD;
                        res_next.payload_byte = b;
                        res_next.last_byte    = last;
                    end
                end
                else if (kind_reg == ID_HAVE || kind_reg == ID_REQUEST || kind_reg == ID_CANCEL
                         || (kind_reg == ID_PIECE && pos_reg < 32'd8))
                begin
                    if (w != 2'd3)
                    begin
                        fw_next[w] = {fw_reg[w][23:0], b};
                    end
                    if (last || (kind_reg == ID_PIECE && pos_reg == 32'd7))
                    begin
                        has_res               = 1'b1;
                        res_next.piece_number = fw_next[0];
                        if (kind_reg == ID_HAVE)
                        begin
                            res_next.kind = EV_HAVE;
                        end
                        else
                        begin
                            res_next.byte_offset = fw_next[1];
                            if (kind_reg == ID_PIECE)
                            begin
                                res_next.kind        = EV_PIECE_START;
                                res_next.span_length = len_reg - 32'd9;
                            end
                            else
                            begin
                                res_next.kind = (kind_reg == ID_REQUEST) ? EV_REQUEST
                                                                         : EV_CANCEL;
                                res_next.span_length = fw_next[2];
                            end
                        end
                    end
                end
                else if (kind_reg == ID_PIECE)
                begin
                    has_res               = 1'b1;
                    res_next.kind         = EV_PIECE_BYTE;
                    res_next.piece_number = fw_reg[0];
                    res_next.byte_offset  = fw_reg[1];
                    res_next.span_length  = len_reg - 32'd9;
                    res_next.payload_byte = b;
                    res_next.last_byte    = last;
                end
                if (last)
                begin
                    pos_next = '0;
                end
            end
            PH_ERR:
            begin
                has_res = 1'b0;
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
        if (go_fault)
        begin
            has_res       = 1'b1;
            res_next.kind = EV_ERROR;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        priority if (go_fault)
        begin
            phase_next = PH_ERR;
        end
        else if (go_end)
        begin
            phase_next = PH_LEN;
        end
        else if (go_id)
        begin
            phase_next = PH_ID;
        end
        else if (go_body)
        begin
            phase_next = PH_BODY;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = has_res;
        end
        else if (ev_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HS;
            pos_reg       <= '0;
            len_reg       <= '0;
            kind_reg      <= '0;
            fw_reg        <= '{default: 32'd0};
            mm_reg        <= MM_NONE;
            diff_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            ih_hi_reg     <= '0;
            ih_mid_reg    <= '0;
            ih_lo_reg     <= '0;
            id_hi_reg     <= '0;
            id_mid_reg    <= '0;
            id_lo_reg     <= '0;
            block_reg     <= 21'd16384;
            pieces_reg    <= 21'd1;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                len_reg   <= len_next;
                kind_reg  <= kind_next;
                fw_reg    <= fw_next;
                mm_reg    <= mm_next;
                diff_reg  <= diff_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_IH_HI:  ih_hi_reg  <= cfg_data;
                    REG_IH_MID: ih_mid_reg <= cfg_data;
                    REG_IH_LO:  ih_lo_reg  <= cfg_data[31:0];
                    REG_ID_HI:  id_hi_reg  <= cfg_data;
                    REG_ID_MID: id_mid_reg <= cfg_data;
                    REG_ID_LO:  id_lo_reg  <= cfg_data[31:0];
                    REG_BLOCK:  block_reg  <= cfg_data[20:0];
                    REG_PIECES: pieces_reg <= cfg_data[20:0];
                    default:    block_reg  <= block_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== hdl/peer_wire_message_parser_top.sv =====
// Peer-link byte parser. One received byte is taken per clock on the rx channel and at most
// one event leaves per byte on the ev channel, in the cycle after the parser takes the byte;
// a two-entry byte queue in front of the parser and the event register behind it let both
// sides stall independently, and the sustained rate is one byte per cycle. The first 68 bytes
// are the handshake (checked against the info hash and own id registers), then length-prefixed
// messages follow. After an error event the block stays silent until reset. Configuration
// registers are to be written by the user only while no byte is in flight (not enforced).
module peer_wire_message_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    output logic        ev_valid,
    input  logic        ev_ready,
    output logic [3:0]  event_kind,
    output logic [31:0] piece_number,
    output logic [31:0] byte_offset,
    output logic [31:0] span_length,
    output logic [7:0]  payload_byte,
    output logic        last_byte,
    output logic [2:0]  fault_code
);
    import pwmp_pkg::*;

    qword_t  head;
    logic    pop;
    result_t res;

    pwmp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_byte  (rx_byte),
        .head     (head),
        .pop      (pop)
    );

    pwmp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .head      (head),
        .pop       (pop),
        .ev_valid  (ev_valid),
        .ev_ready  (ev_ready),
        .res       (res)
    );

    assign event_kind   = res.kind;
    assign piece_number = res.piece_number;
    assign byte_offset  = res.byte_offset;
    assign span_length  = res.span_length;
    assign payload_byte = res.payload_byte;
    assign last_byte    = res.last_byte;
    assign fault_code   = res.fault_code;

endmodule

// ===== hdl/pwmp_checker.sv =====
module pwmp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        ev_valid,
    input logic        ev_ready,
    input logic [3:0]  event_kind,
    input logic        last_byte,
    input logic [2:0]  fault_code
);
    import pwmp_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> ev_valid && $stable(event_kind))
        else $error("event changed while stalled");

    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_ready && event_kind == EV_ERROR |=> !ev_valid)
        else $error("event after error");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && event_kind != EV_ERROR |-> fault_code == FC_NONE)
        else $error("fault code on non-error event");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && last_byte |-> event_kind == EV_BITFIELD || event_kind == EV_PIECE_BYTE)
        else $error("last mark on non-data event");

endmodule

bind peer_wire_message_parser_top pwmp_checker u_pwmp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .ev_valid   (ev_valid),
    .ev_ready   (ev_ready),
    .event_kind (event_kind),
    .last_byte  (last_byte),
    .fault_code (fault_code)
);

// ===== dv/tb_peer_wire_message_parser_top.sv =====
`timescale 1ns / 100ps

module tb_peer_wire_message_parser_top;

    import pwmp_pkg::*;

    localparam logic [7:0] ID_CHOKE = 8'd0;
    localparam logic [7:0] ID_UNINTERESTED = 8'd3;

    typedef enum int {
        MSG_HS,
        MSG_KEEPALIVE,
        MSG_CHOKE,
        MSG_UNCHOKE,
        MSG_INTERESTED,
        MSG_UNINTERESTED,
        MSG_HAVE,
        MSG_BITFIELD,
        MSG_REQUEST,
        MSG_PIECE,
        MSG_CANCEL,
        MSG_UNKNOWN
    } msg_op_t;

    typedef struct {
        logic [7:0] data;
        bit         pinned;
        result_t    pin;
    } rx_item_t;

    typedef struct {
        msg_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        int          dlen;
        logic [7:0]  uid;
        bit          pinned;
        result_t     pin;
    } plan_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        rx_valid;
    logic        rx_ready;
    logic [7:0]  rx_byte;
    logic        ev_valid;
    logic        ev_ready;
    logic [3:0]  event_kind;
    logic [31:0] piece_number;
    logic [31:0] byte_offset;
    logic [31:0] span_length;
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic [2:0]  fault_code;

    peer_wire_message_parser_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .rx_valid(rx_valid),
        .rx_ready(rx_ready),
        .rx_byte(rx_byte),
        .ev_valid(ev_valid),
        .ev_ready(ev_ready),
        .event_kind(event_kind),
        .piece_number(piece_number),
        .byte_offset(byte_offset),
        .span_length(span_length),
        .payload_byte(payload_byte),
        .last_byte(last_byte),
        .fault_code(fault_code)
    );

    // parser copy: configuration
    logic [63:0] ih_hi, ih_mid, id_hi, id_mid;
    logic [31:0] ih_lo, id_lo;
    logic [20:0] blk_bytes, n_pieces;
    // parser copy: state
    phase_t      pp_phase;
    logic [31:0] pp_pos;
    logic [31:0] pp_len;
    logic [7:0]  pp_kind;
    logic [31:0] pp_words [3];
    mismatch_t   pp_mm;

    rx_item_t    byte_q [$];
    rx_item_t    offer_q [$];
    result_t     event_q [$];
    plan_row_t   plan [$];
    int          err_cnt = 0;
    bit          rx_fire = 0;
    int          stall_pct = 0;
    bit          hold_req = 0;
    int          hold_left = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [7:0] key_byte(logic [63:0] hi, logic [63:0] mid,
                                           logic [31:0] lo, int k);
        if (k < 8)
            return hi[8*(7-k) +: 8];
        if (k < 16)
            return mid[8*(15-k) +: 8];
        return lo[8*(19-k) +: 8];
    endfunction

    function automatic int bitfield_bytes();
        return (int'(n_pieces) + 7) / 8;
    endfunction

    function automatic bit raise_fault(input fault_t code, output result_t r);
        r = '0;
        pp_phase = PH_ERR;
        r.kind = EV_ERROR;
        r.fault_code = code;
        return 1'b1;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, output result_t r);
        logic [31:0] p;
        logic        last;
        logic [1:0]  w;
        logic [7:0]  sh;
        r = '0;
        p = pp_pos;
        case (pp_phase)
            PH_HS:
            begin
                if (p < 4)
                begin
                    if (b != HS_STR[159-8*p -: 8])
                        pp_mm = MM_PROTO;
                    if (p == 3 && pp_mm != MM_NONE)
                        return raise_fault(FC_PROTOCOL, r);
                end
                else if (p < 20)
                begin
                    if (b != HS_STR[159-8*p -: 8] && pp_mm == MM_NONE)
                        pp_mm = MM_PROTO;
                end
                else if (p >= 28 && p < 48)
                begin
                    if (b != key_byte(ih_hi, ih_mid, ih_lo, p - 28) && pp_mm == MM_NONE)
                        pp_mm = MM_HASH;
                end
                else if (p >= 48 && p < 68)
                begin
                    if (b != key_byte(id_hi, id_mid, id_lo, p - 48))
                        pp_words[0][0] = 1'b1;
                end
                if (p >= 67)
                begin
                    if (pp_mm == MM_PROTO)
                        return raise_fault(FC_PROTOCOL, r);
                    if (pp_mm != MM_NONE)
                        return raise_fault(FC_HASH, r);
                    if (!pp_words[0][0])
                        return raise_fault(FC_SELF, r);
                    pp_words[0] = '0;
                    pp_phase = PH_LEN;
                    pp_pos = '0;
                    r.kind = EV_HS_OK;
                    return 1'b1;
                end
                pp_pos = p + 1;
                return 1'b0;
            end
            PH_LEN:
            begin
                pp_len = (p == 0) ? {24'd0, b} : {pp_len[23:0], b};
                if (p < 3)
                begin
                    pp_pos = p + 1;
                    return 1'b0;
                end
                pp_pos = '0;
                if ({32'd0, pp_len} > 64'd9 + blk_bytes)
                    return raise_fault(FC_LARGE, r);
                if (pp_len == 0)
                begin
                    r.kind = EV_KEEPALIVE;
                    return 1'b1;
                end
                pp_phase = PH_ID;
                return 1'b0;
            end
            PH_ID:
            begin
                pp_kind = b;
                pp_pos = '0;
                pp_words[0] = '0;
                pp_words[1] = '0;
                pp_words[2] = '0;
                pp_phase = PH_BODY;
                if (b <= ID_UNINTERESTED)
                begin
                    if (pp_len != 1)
                        return raise_fault(FC_LENGTH, r);
                    pp_phase = PH_LEN;
                    r.kind = event_t'(EV_CHOKE + b[3:0]);
                    return 1'b1;
                end
                if (b == ID_HAVE)
                begin
                    if (pp_len != 5)
                        return raise_fault(FC_LENGTH, r);
                    return 1'b0;
                end
                if (b == ID_BITFIELD)
                begin
                    if (pp_len != 1 + bitfield_bytes())
                        return raise_fault(FC_LENGTH, r);
                    if (pp_len == 1)
                        pp_phase = PH_LEN;
                    return 1'b0;
                end
                if (b == ID_REQUEST || b == ID_CANCEL)
                begin
                    if (pp_len != 13)
                        return raise_fault(FC_LENGTH, r);
                    return 1'b0;
                end
                if (b == ID_PIECE)
                begin
                    if (pp_len < 9)
                        return raise_fault(FC_LENGTH, r);
                    return 1'b0;
                end
                if (pp_len == 1)
                    pp_phase = PH_LEN;
                r.kind = EV_SKIPPED;
                return 1'b1;
            end
            PH_BODY:
            begin
                last = (p + 32'd1 == pp_len - 32'd1);
                if (pp_kind == ID_BITFIELD)
                begin
                    sh = b << n_pieces[2:0];
                    if (last && n_pieces[2:0] != 0 && sh != 0)
                        return raise_fault(FC_SPARE, r);
                    r.kind = EV_BITFIELD;
                    r.payload_byte = b;
                    r.last_byte = last;
                end
                else if (pp_kind == ID_HAVE || pp_kind == ID_REQUEST || pp_kind == ID_CANCEL
                         || (pp_kind == ID_PIECE && p < 8))
                begin
                    w = p[3:2];
                    if (w < 3)
                        pp_words[w] = {pp_words[w][23:0], b};
                    if (last || (pp_kind == ID_PIECE && p == 7))
                    begin
                        r.piece_number = pp_words[0];
                        if (pp_kind == ID_HAVE)
                            r.kind = EV_HAVE;
                        else
                        begin
                            r.byte_offset = pp_words[1];
                            if (pp_kind == ID_PIECE)
                            begin
                                r.kind = EV_PIECE_START;
                                r.span_length = pp_len - 9;
                            end
                            else
                            begin
                                r.kind = (pp_kind == ID_REQUEST) ? EV_REQUEST : EV_CANCEL;
                                r.span_length = pp_words[2];
                            end
                        end
                    end
                end
                else if (pp_kind == ID_PIECE)
                begin
                    r.kind = EV_PIECE_BYTE;
                    r.piece_number = pp_words[0];
                    r.byte_offset = pp_words[1];
                    r.span_length = pp_len - 9;
                    r.payload_byte = b;
                    r.last_byte = last;
                end
                if (last)
                begin
                    pp_phase = PH_LEN;
                    pp_pos = '0;
                end
                else
                    pp_pos = p + 1;
                return (r != '0);
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got 0x%0h want 0x%0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    always @(posedge clk)
    begin
        rx_item_t it;
        result_t  r;
        result_t  e;
        if (rst_n)
        begin
            rx_fire = rx_valid && rx_ready;
            if (rx_fire)
            begin
                it = offer_q.pop_front();
                if (parse_byte(it.data, r))
                    event_q.push_back(it.pinned ? it.pin : r);
            end
            if (ev_valid && ev_ready)
            begin
                if (event_q.size() == 0)
                    report("event with none pending, kind", event_kind, 0);
                else
                begin
                    e = event_q.pop_front();
                    if (event_kind != e.kind)
                        report("event_kind", event_kind, e.kind);
                    if (piece_number != e.piece_number)
                        report("piece_number", piece_number, e.piece_number);
                    if (byte_offset != e.byte_offset)
                        report("byte_offset", byte_offset, e.byte_offset);
                    if (span_length != e.span_length)
                        report("span_length", span_length, e.span_length);
                    if (payload_byte != e.payload_byte)
                        report("payload_byte", payload_byte, e.payload_byte);
                    if (last_byte != e.last_byte)
                        report("last_byte", last_byte, e.last_byte);
                    if (fault_code != e.fault_code)
                        report("fault_code", fault_code, e.fault_code);
                end
            end
        end
    end

    // receiver side, with a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            ev_ready <= 1'b0;
        end
        else
            ev_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic result_t only(event_t k);
        result_t r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        int s;
        s = $urandom_range(7);
        if (s == 0)
            return '0;
        if (s == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic push_byte(logic [7:0] d, bit pinned = 0, result_t pin = '0);
        rx_item_t it;
        it.data = d;
        it.pinned = pinned;
        it.pin = pin;
        byte_q.push_back(it);
    endtask

    task automatic push_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            push_byte(w[8*i +: 8]);
    endtask

    task automatic push_msg(plan_row_t m);
        int          n;
        logic [7:0]  d;
        int          flip;
        case (m.op)
            MSG_HS:
            begin
                flip = $urandom_range(19);
                for (int i = 0; i < 20; i++)
                    push_byte(HS_STR[159-8*i -: 8]);
                for (int i = 0; i < 8; i++)
                    push_byte(8'($urandom_range(255)));
                for (int i = 0; i < 20; i++)
                    push_byte(key_byte(ih_hi, ih_mid, ih_lo, i));
                for (int i = 0; i < 19; i++)
                    push_byte(key_byte(id_hi, id_mid, id_lo, i)
                              ^ ((i == flip) ? 8'($urandom_range(1, 255)) : 8'd0));
                d = key_byte(id_hi, id_mid, id_lo, 19) ^ ((flip == 19) ? 8'h5a : 8'd0);
                push_byte(d, m.pinned, m.pin);
            end
            MSG_KEEPALIVE:
            begin
                push_byte(8'd0);
                push_byte(8'd0);
                push_byte(8'd0);
                push_byte(8'd0, m.pinned, m.pin);
            end
            MSG_CHOKE, MSG_UNCHOKE, MSG_INTERESTED, MSG_UNINTERESTED:
            begin
                push_word(32'd1);
                push_byte(ID_CHOKE + 8'(m.op - MSG_CHOKE), m.pinned, m.pin);
            end
            MSG_HAVE:
            begin
                push_word(32'd5);
                push_byte(ID_HAVE);
                push_word(m.a);
            end
            MSG_BITFIELD:
            begin
                n = bitfield_bytes();
                push_word(1 + n);
                push_byte(ID_BITFIELD);
                for (int i = 0; i < n; i++)
                begin
                    d = 8'($urandom_range(255));
                    if (i == n - 1 && n_pieces[2:0] != 0)
                        d = d & ~(8'hff >> n_pieces[2:0]);
                    push_byte(d);
                end
            end
            MSG_REQUEST, MSG_CANCEL:
            begin
                push_word(32'd13);
                push_byte(m.op == MSG_REQUEST ? ID_REQUEST : ID_CANCEL);
                push_word(m.a);
                push_word(m.b);
                push_word(m.c);
            end
            MSG_PIECE:
            begin
                push_word(9 + m.dlen);
                push_byte(ID_PIECE);
                push_word(m.a);
                push_word(m.b);
                for (int i = 0; i < m.dlen; i++)
                    push_byte(8'($urandom_range(255)));
            end
            default:
            begin
                push_word(1 + m.dlen);
                push_byte(m.uid, m.pinned, m.pin);
                for (int i = 0; i < m.dlen; i++)
                    push_byte(8'($urandom_range(255)));
            end
        endcase
    endtask

    task automatic push_random_msg();
        plan_row_t m;
        int        pick;
        int        cap;
        m = '{MSG_KEEPALIVE, rand_word(), rand_word(), rand_word(), 0, 8'd9, 0, '0};
        pick = $urandom_range(99);
        cap = (blk_bytes > 12) ? 12 : int'(blk_bytes);
        if (pick < 5)
            m.op = MSG_KEEPALIVE;
        else if (pick < 15)
            m.op = msg_op_t'(MSG_CHOKE + $urandom_range(3));
        else if (pick < 25)
            m.op = MSG_HAVE;
        else if (pick < 37)
            m.op = (bitfield_bytes() <= 64 && bitfield_bytes() <= blk_bytes + 8)
                   ? MSG_BITFIELD : MSG_HAVE;
        else if (pick < 60)
            m.op = (blk_bytes < 4) ? MSG_CHOKE : (pick < 50 ? MSG_REQUEST : MSG_CANCEL);
        else if (pick < 88)
        begin
            m.op = MSG_PIECE;
            m.dlen = $urandom_range(cap);
            if (pick < 63)
                m.dlen = (blk_bytes > 40) ? 40 : int'(blk_bytes);
        end
        else
        begin
            m.op = MSG_UNKNOWN;
            m.uid = 8'($urandom_range(9, 255));
            m.dlen = $urandom_range(6);
        end
        push_msg(m);
    endtask

    task automatic send_bytes(int idle_pct);
        rx_item_t it;
        while (byte_q.size() > 0)
        begin
            it = byte_q.pop_front();
            while ($urandom_range(99) < idle_pct)
            begin
                rx_valid <= 1'b0;
                @(negedge clk);
            end
            offer_q.push_back(it);
            rx_valid <= 1'b1;
            rx_byte <= it.data;
            do
                @(negedge clk);
            while (!rx_fire);
        end
        rx_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (event_q.size() > 0 || offer_q.size() > 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [63:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_IH_HI: ih_hi = v;
            REG_IH_MID: ih_mid = v;
            REG_IH_LO: ih_lo = v[31:0];
            REG_ID_HI: id_hi = v;
            REG_ID_MID: id_mid = v;
            REG_ID_LO: id_lo = v[31:0];
            REG_BLOCK: blk_bytes = v[20:0];
            default: n_pieces = v[20:0];
        endcase
    endtask

    initial
    begin
        int        send_idle [4] = '{0, 71, 0, 14};
        int        recv_stall [4] = '{0, 0, 71, 14};
        int        blk_set [8] = '{1, 20, 1048576, 64, 3, 16384, 40, 9};
        int        pieces_set [8] = '{1, 9, 1048576, 13, 8, 100, 17, 1};
        int        pick;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rx_valid = 1'b0;
        rx_byte = '0;
        ev_ready = 1'b0;
        ih_hi = '0;
        ih_mid = '0;
        ih_lo = '0;
        id_hi = '0;
        id_mid = '0;
        id_lo = '0;
        blk_bytes = 21'd16384;
        n_pieces = 21'd1;
        pp_phase = PH_HS;
        pp_pos = '0;
        pp_len = '0;
        pp_kind = '0;
        pp_words = '{default: '0};
        pp_mm = MM_NONE;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        cfg_write(REG_IH_HI, {$urandom, $urandom});
        cfg_write(REG_IH_MID, {$urandom, $urandom});
        cfg_write(REG_IH_LO, 64'($urandom));
        cfg_write(REG_ID_HI, {$urandom, $urandom});
        cfg_write(REG_ID_MID, {$urandom, $urandom});
        cfg_write(REG_ID_LO, 64'($urandom));
        cfg_write(REG_BLOCK, 64'd16384);
        cfg_write(REG_PIECES, 64'd1);

        // directed: handshake, every message kind, field extremes
        plan.push_back('{MSG_HS, 0, 0, 0, 0, 0, 1, only(EV_HS_OK)});
        plan.push_back('{MSG_KEEPALIVE, 0, 0, 0, 0, 0, 1, only(EV_KEEPALIVE)});
        plan.push_back('{MSG_CHOKE, 0, 0, 0, 0, 0, 1, only(EV_CHOKE)});
        plan.push_back('{MSG_UNCHOKE, 0, 0, 0, 0, 0, 1, only(EV_UNCHOKE)});
        plan.push_back('{MSG_INTERESTED, 0, 0, 0, 0, 0, 1, only(EV_INTERESTED)});
        plan.push_back('{MSG_UNINTERESTED, 0, 0, 0, 0, 0, 1, only(EV_UNINTERESTED)});
        plan.push_back('{MSG_HAVE, 0, 0, 0, 0, 0, 0, '0});
        plan.push_back('{MSG_HAVE, '1, 0, 0, 0, 0, 0, '0});
        plan.push_back('{MSG_REQUEST, 0, 0, 0, 0, 0, 0, '0});
        plan.push_back('{MSG_REQUEST, '1, '1, '1, 0, 0, 0, '0});
        plan.push_back('{MSG_CANCEL, '1, '1, '1, 0, 0, 0, '0});
        plan.push_back('{MSG_CANCEL, 0, 0, 0, 0, 0, 0, '0});
        plan.push_back('{MSG_PIECE, 32'h12345678, 32'h9abcdef0, 0, 0, 0, 0, '0});
        plan.push_back('{MSG_PIECE, '1, '1, 0, 3, 0, 0, '0});
        plan.push_back('{MSG_BITFIELD, 0, 0, 0, 0, 0, 0, '0});
        plan.push_back('{MSG_UNKNOWN, 0, 0, 0, 0, 8'd9, 1, only(EV_SKIPPED)});
        plan.push_back('{MSG_UNKNOWN, 0, 0, 0, 3, 8'd255, 1, only(EV_SKIPPED)});
        plan.push_back('{MSG_KEEPALIVE, 0, 0, 0, 0, 0, 1, only(EV_KEEPALIVE)});
        foreach (plan[i])
            push_msg(plan[i]);
        stall_pct = 0;
        send_bytes(0);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            cfg_write(REG_BLOCK, 64'(blk_set[ph]));
            cfg_write(REG_PIECES, 64'(pieces_set[ph]));
            stall_pct = recv_stall[ph % 4];
            if (ph == 1)
                hold_req = 1'b1;
            while (byte_q.size() < 115)
                push_random_msg();
            if (ph == 7)
            begin
                // one broken message ends the stream; the parser goes silent after it
                pick = $urandom_range(2);
                if (pick == 0)
                    push_word(blk_bytes + 10);
                else if (pick == 1)
                begin
                    push_word($urandom_range(2, 8));
                    push_byte(ID_PIECE);
                end
                else
                begin
                    push_word(bitfield_bytes() + 1);
                    push_byte(ID_BITFIELD);
                    for (int i = 0; i < bitfield_bytes(); i++)
                        push_byte(8'hff);
                end
                for (int i = 0; i < 12; i++)
                    push_byte(8'($urandom_range(255)));
            end
            send_bytes(send_idle[ph % 4]);
            wait_drained();
        end

        if (err_cnt == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
